/* rtl/core/mrc_pkg.sv */
package mrc_pkg;

    // Antenna count and input packing.
    localparam int ANTENNAS  = 4;
    localparam int PART_W    = 16;
    localparam int CPX_W     = 2 * PART_W;
    localparam int PROD_W    = 2 * PART_W;

    // Per-antenna sums and the combined sums over all antennas.
    localparam int ANT_POW_W    = PROD_W;
    localparam int ANT_M_W      = PROD_W + 1;
    localparam int ANT_SUM_BITS = $clog2(ANTENNAS);
    localparam int POW_W        = ANT_POW_W + ANT_SUM_BITS;
    localparam int M_W          = ANT_M_W + ANT_SUM_BITS;

    // Noise variance register, Q4.12.
    localparam int NV_W = 16;
    localparam logic [NV_W-1:0] NOISE_VAR_RESET = NV_W'(4096);

    // Output formats: symbol Q4.11, variance Q8.16.
    localparam int SYM_W          = 16;
    localparam int SYM_FRAC       = 11;
    localparam int VAR_W          = 24;
    localparam int VAR_FRAC_SHIFT = 30;

    // Quotient bits per divider lane. Each lane produces the variance width
    // plus one bit, and the last bit is used for rounding.
    localparam int QB        = VAR_W + 1;
    localparam int SYM_QB    = SYM_W + 1;
    localparam int SYM_EXTRA = QB - SYM_QB;
    localparam int SYM_SCALE = SYM_FRAC + 1 + SYM_EXTRA;
    localparam int SYM_LOW_W = QB - SYM_SCALE;
    localparam int VAR_SCALE = VAR_FRAC_SHIFT + 1;
    localparam int VAR_UP    = VAR_SCALE - QB;
    localparam int VAR_HI_W  = NV_W + VAR_UP;

    // Pipeline stage positions.
    localparam int ST_PROD  = 0;
    localparam int ST_ANT   = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_PREP  = 3;
    localparam int ST_DIV0  = 4;
    localparam int ST_OUT   = ST_DIV0 + QB;
    localparam int NSTAGES  = ST_OUT + 1;

    typedef logic        [ANT_POW_W-1:0] ant_pow_t;
    typedef logic signed [ANT_M_W-1:0]   ant_m_t;
    typedef logic        [POW_W-1:0]     pow_t;
    typedef logic signed [M_W-1:0]       msum_t;

    // Starting point of one divider lane.
    typedef struct packed {
        logic [POW_W-1:0] rem;
        logic [QB-1:0]    tail;
        logic             sat;
        logic             neg;
    } div_lane_t;

endpackage

/* rtl/core/mrc_ifs.sv */
interface mrc_in_if import mrc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CPX_W-1:0] gain_ant0;
    logic [CPX_W-1:0] gain_ant1;
    logic [CPX_W-1:0] gain_ant2;
    logic [CPX_W-1:0] gain_ant3;
    logic [CPX_W-1:0] sample_ant0;
    logic [CPX_W-1:0] sample_ant1;
    logic [CPX_W-1:0] sample_ant2;
    logic [CPX_W-1:0] sample_ant3;

    modport source (
        output valid, gain_ant0, gain_ant1, gain_ant2, gain_ant3,
               sample_ant0, sample_ant1, sample_ant2, sample_ant3,
        input  ready
    );
    modport sink (
        input  valid, gain_ant0, gain_ant1, gain_ant2, gain_ant3,
               sample_ant0, sample_ant1, sample_ant2, sample_ant3,
        output ready
    );
endinterface

interface mrc_out_if import mrc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SYM_W-1:0] symbol_re;
    logic signed [SYM_W-1:0] symbol_im;
    logic [VAR_W-1:0]        equiv_var;

    modport source (
        output valid, symbol_re, symbol_im, equiv_var,
        input  ready
    );
    modport sink (
        input  valid, symbol_re, symbol_im, equiv_var,
        output ready
    );
endinterface

interface mrc_cfg_if import mrc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [NV_W-1:0] noise_var;

    modport source (
        output valid, noise_var,
        input  ready
    );
    modport sink (
        input  valid, noise_var,
        output ready
    );
endinterface

/* rtl/core/mrc_combiner_4rx_top.sv */
// Channel  Dir  Payload                                        Width
// cfg      in   noise_var (Q4.12)                              16
// din      in   gain_ant0..3, sample_ant0..3 (Q2.13 re | im)   8 x 32
// dout     out  symbol_re, symbol_im (Q4.11), equiv_var (Q8.16) 16, 16, 24
//
// One transaction per cycle on din and dout unless dout stalls; product,
// antenna, sum and setup stages feed the 25-stage quotient pipeline.
// Reset clears all stage valid flags and sets noise_var to 1.0.
// A stage loads whenever it is empty or its content moves on, so bubbles
// close up and din still accepts while dout stalls until all stages fill.
module mrc_combiner_4rx_top
    import mrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mrc_cfg_if.sink   cfg,
    mrc_in_if.sink    din,
    mrc_out_if.source dout
);

    logic [NSTAGES-1:0] valid_reg;
    logic [NSTAGES-1:0] valid_next;
    logic [NSTAGES-1:0] stage_en;
    logic [NV_W-1:0]    noise_var_reg;

    logic [CPX_W-1:0] gains   [4];
    logic [CPX_W-1:0] samples [4];
    ant_pow_t         ant_pow [ANTENNAS];
    ant_m_t           ant_re  [ANTENNAS];
    ant_m_t           ant_im  [ANTENNAS];

    pow_t      divisor;
    div_lane_t lane_re;
    div_lane_t lane_im;
    div_lane_t lane_var;

    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
    logic [QB-1:0] q_var;
    logic          sat_re;
    logic          sat_im;
    logic          sat_var;
    logic          neg_re;
    logic          neg_im;
    logic          neg_var;

    logic signed [SYM_W-1:0] symbol_re_reg;
    logic signed [SYM_W-1:0] symbol_im_reg;
    logic [VAR_W-1:0]        equiv_var_reg;

    // Round the symbol quotient to Q4.11 and saturate.
    function automatic logic [SYM_W-1:0] sym_finish(
        input logic [QB-1:0] q,
        input logic          sat,
        input logic          neg
    );
        logic [SYM_QB:0]   sum;
        logic [SYM_QB-1:0] rnd;
        logic [SYM_W-1:0]  res;
        sum = {1'b0, q[QB-1 -: SYM_QB]} + (SYM_QB+1)'(1);
        rnd = sum[SYM_QB:1];
        if (neg)
        begin
            if (sat || rnd > SYM_QB'(2 ** (SYM_W - 1)))
                res = {1'b1, {(SYM_W-1){1'b0}}};
            else
                res = -rnd[SYM_W-1:0];
        end
        else
        begin
            if (sat || rnd > SYM_QB'(2 ** (SYM_W - 1) - 1))
                res = {1'b0, {(SYM_W-1){1'b1}}};
            else
                res = rnd[SYM_W-1:0];
        end
        return res;
    endfunction

    // Round the variance quotient to Q8.16 and saturate.
    function automatic logic [VAR_W-1:0] var_finish(
        input logic [QB-1:0] q,
        input logic          sat
    );
        logic [QB:0]    sum;
        logic [QB-1:0]  rnd;
        logic [VAR_W-1:0] res;
        sum = {1'b0, q} + (QB+1)'(1);
        rnd = sum[QB:1];
        if (sat || rnd[QB-1])
            res = '1;
        else
            res = rnd[VAR_W-1:0];
        return res;
    endfunction

    // Configuration register; writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            noise_var_reg <= NOISE_VAR_RESET;
        else if (cfg.valid)
            noise_var_reg <= cfg.noise_var;
    end

    // Stage s may load when some stage from s onward is empty or the
    // output transaction completes.
    always_comb
    begin
        for (int s = 0; s < NSTAGES; s++)
        begin
            stage_en[s] = dout.ready ||
                          !(&(valid_reg | ~({NSTAGES{1'b1}} << s)));
        end
        for (int s = 0; s < NSTAGES; s++)
        begin
            if (!stage_en[s])
                valid_next[s] = valid_reg[s];
            else if (s == 0)
                valid_next[s] = din.valid;
            else
                valid_next[s] = valid_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign din.ready  = stage_en[ST_PROD];
    assign dout.valid = valid_reg[ST_OUT];

    // Antenna lanes.
    assign gains[0]   = din.gain_ant0;
    assign gains[1]   = din.gain_ant1;
    assign gains[2]   = din.gain_ant2;
    assign gains[3]   = din.gain_ant3;
    assign samples[0] = din.sample_ant0;
    assign samples[1] = din.sample_ant1;
    assign samples[2] = din.sample_ant2;
    assign samples[3] = din.sample_ant3;

    for (genvar a = 0; a < ANTENNAS; a++)
    begin : g_ant
        mrc_ant_lane u_lane (
            .clk     (clk),
            .en_prod (stage_en[ST_PROD]),
            .en_ant  (stage_en[ST_ANT]),
            .gain    (gains[a]),
            .sample  (samples[a]),
            .ant_pow (ant_pow[a]),
            .ant_re  (ant_re[a]),
            .ant_im  (ant_im[a])
        );
    end

    // Combine the lanes and set up the dividers.
    mrc_merge u_merge (
        .clk       (clk),
        .en_sum    (stage_en[ST_SUM]),
        .en_prep   (stage_en[ST_PREP]),
        .ant_pow   (ant_pow),
        .ant_re    (ant_re),
        .ant_im    (ant_im),
        .noise_var (noise_var_reg),
        .divisor   (divisor),
        .lane_re   (lane_re),
        .lane_im   (lane_im),
        .lane_var  (lane_var)
    );

    // Three divider lanes share the divisor.
    mrc_div_lane u_div_re (
        .clk     (clk),
        .en      (stage_en[ST_DIV0 +: QB]),
        .divisor (divisor),
        .lane    (lane_re),
        .quot    (q_re),
        .sat     (sat_re),
        .neg     (neg_re)
    );

    mrc_div_lane u_div_im (
        .clk     (clk),
        .en      (stage_en[ST_DIV0 +: QB]),
        .divisor (divisor),
        .lane    (lane_im),
        .quot    (q_im),
        .sat     (sat_im),
        .neg     (neg_im)
    );

    mrc_div_lane u_div_var (
        .clk     (clk),
        .en      (stage_en[ST_DIV0 +: QB]),
        .divisor (divisor),
        .lane    (lane_var),
        .quot    (q_var),
        .sat     (sat_var),
        .neg     (neg_var)
    );

    // Output register: rounding and saturation.
    always_ff @(posedge clk)
    begin
        if (stage_en[ST_OUT])
        begin
            symbol_re_reg <= sym_finish(q_re, sat_re, neg_re);
            symbol_im_reg <= sym_finish(q_im, sat_im, neg_im);
            equiv_var_reg <= var_finish(q_var, sat_var || neg_var);
        end
    end

    assign dout.symbol_re = symbol_re_reg;
    assign dout.symbol_im = symbol_im_reg;
    assign dout.equiv_var = equiv_var_reg;

endmodule

/* rtl/core/mrc_ant_lane.sv */
module mrc_ant_lane
    import mrc_pkg::*;
(
    input  logic             clk,
    input  logic             en_prod,
    input  logic             en_ant,
    input  logic [CPX_W-1:0] gain,
    input  logic [CPX_W-1:0] sample,
    output ant_pow_t         ant_pow,
    output ant_m_t           ant_re,
    output ant_m_t           ant_im
);

    logic signed [PART_W-1:0] hr;
    logic signed [PART_W-1:0] hi;
    logic signed [PART_W-1:0] rr;
    logic signed [PART_W-1:0] ri;

    logic signed [PROD_W-1:0] hrhr_reg;
    logic signed [PROD_W-1:0] hihi_reg;
    logic signed [PROD_W-1:0] hrrr_reg;
    logic signed [PROD_W-1:0] hiri_reg;
    logic signed [PROD_W-1:0] hrri_reg;
    logic signed [PROD_W-1:0] hirr_reg;

    ant_pow_t pow_reg;
    ant_m_t   re_reg;
    ant_m_t   im_reg;

    // Unpack the real and imaginary halves.
    assign hr = gain[CPX_W-1:PART_W];
    assign hi = gain[PART_W-1:0];
    assign rr = sample[CPX_W-1:PART_W];
    assign ri = sample[PART_W-1:0];

    // Six exact products, one register stage.
    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            hrhr_reg <= hr * hr;
            hihi_reg <= hi * hi;
            hrrr_reg <= hr * rr;
            hiri_reg <= hi * ri;
            hrri_reg <= hr * ri;
            hirr_reg <= hi * rr;
        end
    end

    // Channel power and conjugate-weighted sample for this antenna.
    always_ff @(posedge clk)
    begin
        if (en_ant)
        begin
            pow_reg <= ANT_POW_W'($unsigned(hrhr_reg)) + ANT_POW_W'($unsigned(hihi_reg));
            re_reg  <= ANT_M_W'(hrrr_reg) + ANT_M_W'(hiri_reg);
            im_reg  <= ANT_M_W'(hrri_reg) - ANT_M_W'(hirr_reg);
        end
    end

    assign ant_pow = pow_reg;
    assign ant_re  = re_reg;
    assign ant_im  = im_reg;

endmodule

/* rtl/core/mrc_merge.sv */
module mrc_merge
    import mrc_pkg::*;
(
    input  logic            clk,
    input  logic            en_sum,
    input  logic            en_prep,
    input  ant_pow_t        ant_pow [ANTENNAS],
    input  ant_m_t          ant_re  [ANTENNAS],
    input  ant_m_t          ant_im  [ANTENNAS],
    input  logic [NV_W-1:0] noise_var,
    output pow_t            divisor,
    output div_lane_t       lane_re,
    output div_lane_t       lane_im,
    output div_lane_t       lane_var
);

    pow_t      pow_sum_next;
    msum_t     re_sum_next;
    msum_t     im_sum_next;
    pow_t      pow_sum_reg;
    msum_t     re_sum_reg;
    msum_t     im_sum_reg;

    pow_t      dvs;
    pow_t      divisor_reg;
    div_lane_t lane_re_reg;
    div_lane_t lane_im_reg;
    div_lane_t lane_var_reg;

    // Symbol lane: magnitude of the combined sample, scaled so that the
    // quotient carries the rounding and spare bits below Q4.11.
    function automatic div_lane_t sym_lane(input msum_t m, input pow_t d);
        logic [M_W-1:0] mag;
        logic [M_W-1:0] hi_part;
        div_lane_t      l;
        mag     = m[M_W-1] ? M_W'(-m) : M_W'(m);
        hi_part = mag >> SYM_LOW_W;
        l.neg   = m[M_W-1];
        l.sat   = (hi_part >= M_W'(d));
        l.rem   = l.sat ? '0 : POW_W'(hi_part);
        l.tail  = {mag[SYM_LOW_W-1:0], {(QB-SYM_LOW_W){1'b0}}};
        return l;
    endfunction

    // Sum the antenna lanes.
    always_comb
    begin
        pow_sum_next = '0;
        re_sum_next  = '0;
        im_sum_next  = '0;
        for (int a = 0; a < ANTENNAS; a++)
        begin
            pow_sum_next = pow_sum_next + POW_W'(ant_pow[a]);
            re_sum_next  = re_sum_next + M_W'(ant_re[a]);
            im_sum_next  = im_sum_next + M_W'(ant_im[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            pow_sum_reg <= pow_sum_next;
            re_sum_reg  <= re_sum_next;
            im_sum_reg  <= im_sum_next;
        end
    end

    // Zero power is floored to one LSB.
    assign dvs = (pow_sum_reg == '0) ? POW_W'(1) : pow_sum_reg;

    // Set up the three divider lanes and flag quotients that will saturate.
    always_ff @(posedge clk)
    begin
        if (en_prep)
        begin
            divisor_reg       <= dvs;
            lane_re_reg       <= sym_lane(re_sum_reg, dvs);
            lane_im_reg       <= sym_lane(im_sum_reg, dvs);
            lane_var_reg.neg  <= 1'b0;
            lane_var_reg.tail <= '0;
            if (POW_W'({noise_var, {VAR_UP{1'b0}}}) >= dvs)
            begin
                lane_var_reg.sat <= 1'b1;
                lane_var_reg.rem <= '0;
            end
            else
            begin
                lane_var_reg.sat <= 1'b0;
                lane_var_reg.rem <= POW_W'({noise_var, {VAR_UP{1'b0}}});
            end
        end
    end

    assign divisor  = divisor_reg;
    assign lane_re  = lane_re_reg;
    assign lane_im  = lane_im_reg;
    assign lane_var = lane_var_reg;

endmodule

/* rtl/core/mrc_div_lane.sv */
module mrc_div_lane
    import mrc_pkg::*;
(
    input  logic          clk,
    input  logic [QB-1:0] en,
    input  pow_t          divisor,
    input  div_lane_t     lane,
    output logic [QB-1:0] quot,
    output logic          sat,
    output logic          neg
);

    pow_t             dvs_reg  [QB];
    logic [POW_W-1:0] rem_reg  [QB];
    logic [QB-1:0]    tail_reg [QB];
    logic [QB-1:0]    quot_reg [QB];
    logic             sat_reg  [QB];
    logic             neg_reg  [QB];

    // One restoring step per stage: shift in the next dividend bit,
    // subtract the divisor when it fits, and record the quotient bit.
    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        pow_t             d_in;
        logic [POW_W-1:0] r_in;
        logic [QB-1:0]    t_in;
        logic [QB-1:0]    q_in;
        logic             sat_in;
        logic             neg_in;
        logic [POW_W:0]   shifted;
        logic [POW_W:0]   trial;
        logic             take;

        if (s == 0)
        begin : g_first
            assign d_in   = divisor;
            assign r_in   = lane.rem;
            assign t_in   = lane.tail;
            assign q_in   = '0;
            assign sat_in = lane.sat;
            assign neg_in = lane.neg;
        end
        else
        begin : g_next
            assign d_in   = dvs_reg[s-1];
            assign r_in   = rem_reg[s-1];
            assign t_in   = tail_reg[s-1];
            assign q_in   = quot_reg[s-1];
            assign sat_in = sat_reg[s-1];
            assign neg_in = neg_reg[s-1];
        end

        always_comb
        begin
            shifted = {r_in, t_in[QB-1]};
            trial   = shifted - {1'b0, d_in};
            take    = (shifted >= {1'b0, d_in});
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                dvs_reg[s]  <= d_in;
                rem_reg[s]  <= take ? trial[POW_W-1:0] : shifted[POW_W-1:0];
                tail_reg[s] <= t_in << 1;
                quot_reg[s] <= {q_in[QB-2:0], take};
                sat_reg[s]  <= sat_in;
                neg_reg[s]  <= neg_in;
            end
        end
    end

    assign quot = quot_reg[QB-1];
    assign sat  = sat_reg[QB-1];
    assign neg  = neg_reg[QB-1];

endmodule
